// ===== rtl/trpe_pkg.sv =====
package trpe_pkg;

  localparam int SLOT_CAP     = 3;
  localparam int INSTR_CFG    = 5;
  localparam int DATA_W       = 32;
  localparam int INSTR_W      = 11;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 11;
  localparam int CNT_W        = 2;

  localparam int NUM_INSTR_DEF = 5;
  localparam int NUM_SLOTS_DEF = 3;
  localparam int NUM_REGS_DEF  = 3;

  // instruction word fields
  localparam int OP_LSB   = 8;
  localparam int DEST_LSB = 5;

  // operand code ranges
  localparam logic [2:0] DEST_REG_BASE = 3'd3;
  localparam logic [2:0] DEST_MAX      = 3'd5;
  localparam logic [4:0] SRC_REG_BASE  = 5'd3;
  localparam logic [4:0] LIT_BASE      = 5'd6;
  localparam logic [4:0] SRC_END       = 5'd26;

  localparam logic [INSTR_W-1:0] NOP_WORD = 11'd1280;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_INPUTS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_OUTPUTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INSTR_BASE  = 3'd2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOV = 3'd4
  } op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] in_value_0;
    logic signed [DATA_W-1:0] in_value_1;
    logic signed [DATA_W-1:0] in_value_2;
  } in_data_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value_0;
    logic signed [DATA_W-1:0] out_value_1;
    logic signed [DATA_W-1:0] out_value_2;
    logic                     div_zero_flag;
  } out_data_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

endpackage

// ===== rtl/trpe_alu.sv =====
module trpe_alu
  import trpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  alu_req_t          req,
  input  logic [DATA_W-1:0] opa,
  input  logic [DATA_W-1:0] opb,
  output alu_rsp_t          rsp,
  output logic [DATA_W-1:0] result
);

  typedef enum logic {
    A_IDLE,
    A_DIV
  } alu_state_t;

  alu_state_t        state_r, state_nxt;
  logic              done_r, done_nxt;
  logic              dz_r, dz_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic [DATA_W-1:0] quot_r, quot_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] mb_r, mb_nxt;
  logic              neg_r, neg_nxt;
  logic [4:0]        cnt_r, cnt_nxt;

  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] q_step;
  logic [DATA_W-1:0] prod;

  assign prod = opa * opb;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    dz_nxt    = 1'b0;
    res_nxt   = res_r;
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    mb_nxt    = mb_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    trial     = {rem_r, quot_r[DATA_W-1]} - {1'b0, mb_r};
    q_step    = {quot_r[DATA_W-2:0], ~trial[DATA_W]};
    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          case (req.op)
            OP_ADD: begin
              res_nxt  = opa + opb;
              done_nxt = 1'b1;
            end
            OP_SUB: begin
              res_nxt  = opa - opb;
              done_nxt = 1'b1;
            end
            OP_MUL: begin
              res_nxt  = prod;
              done_nxt = 1'b1;
            end
            OP_DIV: begin
              if (opb == '0) begin
                res_nxt  = '0;
                dz_nxt   = 1'b1;
                done_nxt = 1'b1;
              end else begin
                // work on magnitudes, fix the sign at the end
                quot_nxt  = opa[DATA_W-1] ? (DATA_W'(0) - opa) : opa;
                mb_nxt    = opb[DATA_W-1] ? (DATA_W'(0) - opb) : opb;
                neg_nxt   = opa[DATA_W-1] ^ opb[DATA_W-1];
                rem_nxt   = '0;
                cnt_nxt   = 5'(DATA_W - 1);
                state_nxt = A_DIV;
              end
            end
            default: begin
              res_nxt  = opb;
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      A_DIV: begin
        // one restoring step per cycle
        if (trial[DATA_W]) begin
          rem_nxt = {rem_r[DATA_W-2:0], quot_r[DATA_W-1]};
        end else begin
          rem_nxt = trial[DATA_W-1:0];
        end
        quot_nxt = q_step;
        if (cnt_r == '0) begin
          res_nxt   = neg_r ? (DATA_W'(0) - q_step) : q_step;
          done_nxt  = 1'b1;
          state_nxt = A_IDLE;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
      dz_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      dz_r    <= dz_nxt;
    end
    res_r  <= res_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    mb_r   <= mb_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.div_zero = dz_r;
  assign result       = res_r;

endmodule

// ===== rtl/tiny_register_program_executor.sv =====
// Per item: load the inputs, run each valid instruction through the shared ALU
// (a divide by a nonzero divisor takes 32 restoring steps there), pass over a
// skipped instruction without the ALU, and report the result.
// Throughput: one item at a time; in_ready is high only while idle.
// Reset (rst_n, synchronous): program words read as nop, num_inputs and
// num_outputs read 3, no result pending.
module tiny_register_program_executor
  import trpe_pkg::*;
#(
  parameter int NUM_INSTR = NUM_INSTR_DEF,
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int NUM_REGS  = NUM_REGS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_data_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_data_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PC_W = (NUM_INSTR > 1) ? $clog2(NUM_INSTR) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [PC_W-1:0]    pc_r, pc_nxt;
  logic [DATA_W-1:0]  slot_r [NUM_SLOTS];
  logic [DATA_W-1:0]  slot_nxt [NUM_SLOTS];
  logic [DATA_W-1:0]  reg_r [NUM_REGS];
  logic [DATA_W-1:0]  reg_nxt [NUM_REGS];
  logic               flag_r, flag_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_data_t          out_data_r, out_data_nxt;

  logic [CNT_W-1:0]   num_inputs_r;
  logic [CNT_W-1:0]   num_outputs_r;
  logic [INSTR_W-1:0] prog_r [INSTR_CFG];

  logic [INSTR_W-1:0] word;
  logic [2:0]         op_code;
  logic [2:0]         dest;
  logic [4:0]         src;
  logic               instr_ok;
  logic               last_instr;
  logic [DATA_W-1:0]  opa;
  logic [DATA_W-1:0]  opb;
  logic [DATA_W-1:0]  in_vals [SLOT_CAP];
  logic [DATA_W-1:0]  out_vals [SLOT_CAP];

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic [DATA_W-1:0]  alu_result;

  trpe_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opa    (opa),
    .opb    (opb),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  assign in_vals[0] = in_data.in_value_0;
  assign in_vals[1] = in_data.in_value_1;
  assign in_vals[2] = in_data.in_value_2;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_inputs_r  <= CNT_W'(SLOT_CAP);
      num_outputs_r <= CNT_W'(SLOT_CAP);
      for (int i = 0; i < INSTR_CFG; i++) begin
        prog_r[i] <= NOP_WORD;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_NUM_INPUTS) begin
        num_inputs_r <= cfg_wdata[CNT_W-1:0];
      end else if (cfg_index == CFG_NUM_OUTPUTS) begin
        num_outputs_r <= cfg_wdata[CNT_W-1:0];
      end
      for (int i = 0; i < INSTR_CFG; i++) begin
        if (cfg_index == CFG_INSTR_BASE + CFG_IDX_W'(i)) begin
          prog_r[i] <= cfg_wdata[INSTR_W-1:0];
        end
      end
    end
  end

  // instruction decode and operand fetch
  always_comb begin
    word = NOP_WORD;
    for (int i = 0; i < INSTR_CFG; i++) begin
      if (i < NUM_INSTR && {1'b0, pc_r} == (PC_W+1)'(i)) begin
        word = prog_r[i];
      end
    end
    op_code = word[INSTR_W-1:OP_LSB];
    dest    = word[OP_LSB-1:DEST_LSB];
    src     = word[DEST_LSB-1:0];

    instr_ok = (op_code <= OP_MOV) && (dest <= DEST_MAX) && (src < SRC_END);
    if (dest < DEST_REG_BASE) begin
      if ({29'd0, dest} >= NUM_SLOTS) begin
        instr_ok = 1'b0;
      end
    end else if ({29'd0, dest - DEST_REG_BASE} >= NUM_REGS) begin
      instr_ok = 1'b0;
    end

    opa = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (dest == 3'(i)) begin
        opa = slot_r[i];
      end
    end
    for (int i = 0; i < NUM_REGS; i++) begin
      if (dest == DEST_REG_BASE + 3'(i)) begin
        opa = reg_r[i];
      end
    end

    opb = '0;
    if (src >= LIT_BASE) begin
      opb = DATA_W'(src - LIT_BASE);
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (src == 5'(i)) begin
        opb = slot_r[i];
      end
    end
    for (int i = 0; i < NUM_REGS; i++) begin
      if (src == SRC_REG_BASE + 5'(i)) begin
        opb = reg_r[i];
      end
    end

    last_instr = ({1'b0, pc_r} == (PC_W+1)'(NUM_INSTR - 1));
  end

  assign alu_req.start = (state_r == S_ISSUE) && instr_ok;
  assign alu_req.op    = op_t'(op_code);
  assign in_ready      = (state_r == S_IDLE);

  always_comb begin
    for (int i = 0; i < SLOT_CAP; i++) begin
      out_vals[i] = '0;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if ({30'd0, num_outputs_r} > i) begin
        out_vals[i] = slot_r[i];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    slot_nxt      = slot_r;
    reg_nxt       = reg_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // drop the result once it transfers
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_nxt[i] = ({30'd0, num_inputs_r} > i) ? in_vals[i] : '0;
          end
          for (int i = 0; i < NUM_REGS; i++) begin
            reg_nxt[i] = '0;
          end
          flag_nxt  = 1'b0;
          pc_nxt    = '0;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (instr_ok) begin
          state_nxt = S_WAIT;
        end else if (last_instr) begin
          state_nxt = S_DONE;
        end else begin
          pc_nxt = pc_r + PC_W'(1);
        end
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (dest == 3'(i)) begin
              slot_nxt[i] = alu_result;
            end
          end
          for (int i = 0; i < NUM_REGS; i++) begin
            if (dest == DEST_REG_BASE + 3'(i)) begin
              reg_nxt[i] = alu_result;
            end
          end
          flag_nxt = flag_r | alu_rsp.div_zero;
          if (last_instr) begin
            state_nxt = S_DONE;
          end else begin
            pc_nxt    = pc_r + PC_W'(1);
            state_nxt = S_ISSUE;
          end
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_data_nxt.out_value_0   = out_vals[0];
          out_data_nxt.out_value_1   = out_vals[1];
          out_data_nxt.out_value_2   = out_vals[2];
          out_data_nxt.div_zero_flag = flag_r;
          out_valid_nxt              = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pc_r       <= pc_nxt;
    slot_r     <= slot_nxt;
    reg_r      <= reg_nxt;
    flag_r     <= flag_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== verif/tiny_register_program_executor_test.sv =====
`timescale 1ns / 1ps

module tiny_register_program_executor_test;
  import trpe_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 200;
  localparam int RANDOM_ITEMS  = 650;
  localparam int BURST_ITEMS   = 50;

  // ops past OP_MOV are skipped
  localparam logic [2:0] OP_NOP    = 3'd5;
  localparam logic [2:0] OP_NOP_HI = 3'd7;

  localparam logic [2:0] D_SLOT0   = 3'd0;
  localparam logic [2:0] D_SLOT1   = 3'd1;
  localparam logic [2:0] D_SLOT2   = 3'd2;
  localparam logic [2:0] D_REG0    = DEST_REG_BASE;
  localparam logic [2:0] D_REG1    = DEST_REG_BASE + 3'd1;
  localparam logic [2:0] D_REG2    = DEST_REG_BASE + 3'd2;
  localparam logic [2:0] D_NONE    = DEST_MAX + 3'd1;
  localparam logic [2:0] D_NONE_HI = 3'd7;

  localparam logic [4:0] S_SLOT0   = 5'd0;
  localparam logic [4:0] S_SLOT1   = 5'd1;
  localparam logic [4:0] S_SLOT2   = 5'd2;
  localparam logic [4:0] S_REG0    = SRC_REG_BASE;
  localparam logic [4:0] S_REG1    = SRC_REG_BASE + 5'd1;
  localparam logic [4:0] S_REG2    = SRC_REG_BASE + 5'd2;
  localparam logic [4:0] S_NONE    = SRC_END;
  localparam logic [4:0] S_NONE_HI = 5'd31;

  localparam logic [CFG_IDX_W-1:0] CFG_INSTR_4    = CFG_INSTR_BASE + 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_INSTR_BASE + 3'd5;

  localparam logic [DATA_W-1:0] V_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] V_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] V_NEG = 32'hffff_ffff;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_data_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_data_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // shadow of the block's configuration
  logic [CNT_W-1:0]   inputs_loaded;
  logic [CNT_W-1:0]   outputs_shown;
  logic [INSTR_W-1:0] prog_words [INSTR_CFG];

  out_data_t program_outputs_q [$];
  int        error_count;
  int        cycle_count;
  bit        gaps_on;
  bit        stalls_on;

  tiny_register_program_executor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [INSTR_W-1:0] encode(logic [2:0] op, logic [2:0] dst,
                                                logic [4:0] src);
    return {op, dst, src};
  endfunction

  function automatic in_data_t make_item(logic [DATA_W-1:0] v0, logic [DATA_W-1:0] v1,
                                         logic [DATA_W-1:0] v2);
    in_data_t d;
    d.in_value_0 = v0;
    d.in_value_1 = v1;
    d.in_value_2 = v2;
    return d;
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return V_MIN;
      1: return V_MAX;
      2: return '0;
      3: return V_NEG;
      4: return $urandom_range(0, 1) ? $urandom_range(0, 20) : -$urandom_range(1, 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [INSTR_W-1:0] rand_instr();
    if ($urandom_range(0, 9) == 0)
      return INSTR_W'($urandom_range(0, 2047));
    return encode(3'($urandom_range(0, 4)), 3'($urandom_range(0, 5)),
                  5'($urandom_range(0, 25)));
  endfunction

  function automatic out_data_t execute_program(in_data_t item);
    logic [DATA_W-1:0]  slot [SLOT_CAP];
    logic [DATA_W-1:0]  regs [SLOT_CAP];
    logic [DATA_W-1:0]  acc;
    logic [DATA_W-1:0]  operand;
    logic [DATA_W-1:0]  mag_a;
    logic [DATA_W-1:0]  mag_b;
    logic [DATA_W-1:0]  quot;
    logic [INSTR_W-1:0] word;
    logic [2:0]         op;
    logic [2:0]         dst;
    logic [4:0]         src;
    logic               flag;
    out_data_t          res;
    slot[0] = (inputs_loaded > 2'd0) ? item.in_value_0 : '0;
    slot[1] = (inputs_loaded > 2'd1) ? item.in_value_1 : '0;
    slot[2] = (inputs_loaded > 2'd2) ? item.in_value_2 : '0;
    for (int r = 0; r < SLOT_CAP; r++) regs[r] = '0;
    flag = 1'b0;
    for (int i = 0; i < INSTR_CFG; i++) begin
      word = prog_words[i];
      op   = word[OP_LSB +: 3];
      dst  = word[DEST_LSB +: 3];
      src  = word[4:0];
      if (op <= OP_MOV && dst <= DEST_MAX && src < SRC_END) begin
        acc = (dst < DEST_REG_BASE) ? slot[dst[1:0]] : regs[2'(dst - DEST_REG_BASE)];
        if (src < SRC_REG_BASE)
          operand = slot[src[1:0]];
        else if (src < LIT_BASE)
          operand = regs[2'(src - SRC_REG_BASE)];
        else
          operand = DATA_W'(src - LIT_BASE);
        case (op)
          OP_ADD: acc = acc + operand;
          OP_SUB: acc = acc - operand;
          OP_MUL: acc = acc * operand;
          OP_DIV: begin
            if (operand == '0) begin
              acc  = '0;
              flag = 1'b1;
            end else begin
              // divide magnitudes, then restore the sign: truncates toward zero
              mag_a = acc[DATA_W-1] ? -acc : acc;
              mag_b = operand[DATA_W-1] ? -operand : operand;
              quot  = mag_a / mag_b;
              acc   = (acc[DATA_W-1] ^ operand[DATA_W-1]) ? -quot : quot;
            end
          end
          default: acc = operand;
        endcase
        if (dst < DEST_REG_BASE)
          slot[dst[1:0]] = acc;
        else
          regs[2'(dst - DEST_REG_BASE)] = acc;
      end
    end
    res.out_value_0   = (outputs_shown > 2'd0) ? slot[0] : '0;
    res.out_value_1   = (outputs_shown > 2'd1) ? slot[1] : '0;
    res.out_value_2   = (outputs_shown > 2'd2) ? slot[2] : '0;
    res.div_zero_flag = flag;
    return res;
  endfunction

  task automatic report_error(string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    if (got !== want)
      report_error($sformatf("%s got %h, want %h", name, got, want));
  endtask

  // called at a clock edge; returns at the edge of the transfer with in_valid still high
  task automatic send_item(in_data_t d);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    program_outputs_q.push_back(execute_program(d));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (program_outputs_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NUM_INPUTS)
      inputs_loaded = val[CNT_W-1:0];
    else if (idx == CFG_NUM_OUTPUTS)
      outputs_shown = val[CNT_W-1:0];
    else if (idx < CFG_UNUSED_IDX)
      prog_words[idx - CFG_INSTR_BASE] = val;
    @(posedge clk);
  endtask

  task automatic write_program(logic [INSTR_W-1:0] w0, logic [INSTR_W-1:0] w1,
                               logic [INSTR_W-1:0] w2, logic [INSTR_W-1:0] w3,
                               logic [INSTR_W-1:0] w4);
    write_reg(CFG_INSTR_BASE,         w0);
    write_reg(CFG_INSTR_BASE + 3'd1,  w1);
    write_reg(CFG_INSTR_BASE + 3'd2,  w2);
    write_reg(CFG_INSTR_BASE + 3'd3,  w3);
    write_reg(CFG_INSTR_4,            w4);
  endtask

  task automatic test_reset_defaults();
    send_item(make_item(V_MAX, V_MIN, V_NEG));
    send_item(make_item('0, 32'd1, V_MIN));
    drain_results();
  endtask

  task automatic test_arith_ops();
    write_program(encode(OP_MOV, D_REG0, LIT_BASE + 5'd19),
                  encode(OP_ADD, D_SLOT0, S_REG0),
                  encode(OP_SUB, D_SLOT1, S_SLOT0),
                  encode(OP_MUL, D_SLOT2, S_SLOT1),
                  encode(OP_ADD, D_REG1, LIT_BASE));
    send_item(make_item(V_MAX, V_MIN, V_NEG));
    send_item(make_item('0, '0, '0));
    send_item(make_item(V_MIN, V_MAX, 32'd1));
    drain_results();
  endtask

  task automatic test_divide();
    write_program(encode(OP_DIV, D_SLOT0, S_SLOT1),
                  encode(OP_DIV, D_SLOT2, S_SLOT2),
                  encode(OP_MOV, D_REG2, S_SLOT0),
                  encode(OP_DIV, D_REG2, LIT_BASE + 5'd7),
                  encode(OP_ADD, D_SLOT1, S_REG2));
    // most negative over minus one, and a zero divisor in slot 2
    send_item(make_item(V_MIN, V_NEG, '0));
    send_item(make_item(32'd7, -32'sd2, -32'sd5));
    send_item(make_item(-32'sd7, 32'd2, V_MIN));
    send_item(make_item(32'd5, '0, 32'd3));
    drain_results();
  endtask

  task automatic test_skipped_instrs();
    write_program(encode(OP_NOP, D_SLOT0, LIT_BASE + 5'd1),
                  encode(OP_NOP_HI, D_SLOT1, LIT_BASE + 5'd2),
                  encode(OP_ADD, D_NONE, LIT_BASE + 5'd3),
                  encode(OP_ADD, D_NONE_HI, LIT_BASE + 5'd4),
                  encode(OP_MOV, D_SLOT2, S_NONE));
    send_item(make_item(32'd1, 32'd2, 32'd3));
    drain_results();
    write_reg(CFG_INSTR_4, encode(OP_MOV, D_SLOT2, S_NONE_HI));
    send_item(make_item(V_NEG, V_MAX, V_MIN));
    drain_results();
  endtask

  task automatic test_slot_counts();
    int n_in  [4];
    int n_out [4];
    n_in  = '{0, 1, 2, 3};
    n_out = '{3, 1, 2, 0};
    // slot 2 folds into slot 0 so an unloaded slot shows up as zero
    write_program(encode(OP_ADD, D_SLOT0, S_SLOT2), NOP_WORD, NOP_WORD, NOP_WORD,
                  NOP_WORD);
    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_NUM_INPUTS, 11'h7fc | CFG_DATA_W'(n_in[k]));
      write_reg(CFG_NUM_OUTPUTS, 11'h7fc | CFG_DATA_W'(n_out[k]));
      send_item(make_item(V_MAX, V_NEG, 32'd9));
      drain_results();
    end
  endtask

  task automatic test_unused_index();
    write_reg(CFG_NUM_INPUTS, 11'd3);
    write_reg(CFG_NUM_OUTPUTS, 11'd3);
    write_reg(CFG_UNUSED_IDX, 11'h7ff);
    send_item(make_item(32'd4, V_MIN, 32'd5));
    drain_results();
  endtask

  task automatic test_random_programs();
    int sent;
    int phase;
    int count;
    int pause_at;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      write_reg(CFG_NUM_INPUTS, CFG_DATA_W'($urandom_range(0, 2047)));
      write_reg(CFG_NUM_OUTPUTS, CFG_DATA_W'($urandom_range(0, 2047)));
      write_program(rand_instr(), rand_instr(), rand_instr(), rand_instr(), rand_instr());
      if ($urandom_range(0, 4) == 0)
        write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom_range(0, 2047)));
      count    = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(10, 40);
      pause_at = (phase == 0 || $urandom_range(0, 3) == 0) ? count / 2 : -1;
      for (int k = 0; k < count; k++) begin
        // hold the sender until the block has emptied
        if (k == pause_at && k != 0)
          drain_results();
        send_item(make_item(rand_value(), rand_value(), rand_value()));
      end
      sent += count;
      phase++;
      drain_results();
    end
  endtask

  task automatic test_back_to_back();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_reg(CFG_NUM_INPUTS, 11'd3);
    write_reg(CFG_NUM_OUTPUTS, 11'd3);
    write_program(rand_instr(), rand_instr(), rand_instr(), rand_instr(), rand_instr());
    for (int k = 0; k < BURST_ITEMS; k++)
      send_item(make_item(rand_value(), rand_value(), rand_value()));
    drain_results();
  endtask

  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    out_data_t want;
    if (rst_n && out_valid && out_ready) begin
      if (program_outputs_q.size() == 0) begin
        report_error("result transfer with nothing outstanding");
      end else begin
        want = program_outputs_q.pop_front();
        check_field("out_value_0", out_data.out_value_0, want.out_value_0);
        check_field("out_value_1", out_data.out_value_1, want.out_value_1);
        check_field("out_value_2", out_data.out_value_2, want.out_value_2);
        check_field("div_zero_flag", DATA_W'(out_data.div_zero_flag),
                    DATA_W'(want.div_zero_flag));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    error_count   = 0;
    cycle_count   = 0;
    gaps_on       = 1'b0;
    stalls_on     = 1'b0;
    inputs_loaded = 2'd3;
    outputs_shown = 2'd3;
    for (int i = 0; i < INSTR_CFG; i++) prog_words[i] = NOP_WORD;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_arith_ops();
    test_divide();
    test_skipped_instrs();
    test_slot_counts();
    test_unused_index();
    test_random_programs();
    test_back_to_back();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
